[sv/timestamp_sync_trigger_scheduler_assert.svh]
// Assertion macros for the trigger scheduler.
`ifndef TIMESTAMP_SYNC_TRIGGER_SCHEDULER_ASSERT_SVH
`define TIMESTAMP_SYNC_TRIGGER_SCHEDULER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TSTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define TSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/tsts_pkg.sv]
package tsts_pkg;

  localparam int unsigned WindowDepth = 10;
  localparam int unsigned WinIdxW     = $clog2(WindowDepth);
  localparam int unsigned FillW       = $clog2(WindowDepth + 1);
  localparam logic [31:0] MaxPeriods  = 32'd65535;
  localparam int unsigned IdW         = 29;
  localparam logic [IdW-1:0] SyncIdReset   = 29'd83820783;
  localparam logic [IdW-1:0] GlobalIdReset = 29'd83821039;

  localparam logic CfgSyncId   = 1'b0;
  localparam logic CfgGlobalId = 1'b1;

  // Request to the search engine and its status back.
  typedef struct packed {
    logic start;
    logic strict_mode;
  } srch_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srch_sts_t;

endpackage

[sv/tsts_window.sv]
`include "timestamp_sync_trigger_scheduler_assert.svh"

module tsts_window
  import tsts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic                 shift_i,
  input  logic [WinIdxW-1:0]   wr_idx_i,
  input  logic [31:0]          wr_data_i,
  input  logic [WinIdxW-1:0]   rd_idx_i,
  output logic [31:0]          rd_data_o
);

  logic [31:0] win_q [WindowDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (shift_i) begin
        for (int k = 0; k < WindowDepth - 1; k++) begin
          win_q[k] <= win_q[k+1];
        end
        win_q[WindowDepth-1] <= wr_data_i;
      end else begin
        win_q[wr_idx_i] <= wr_data_i;
      end
    end
  end

  assign rd_data_o = win_q[rd_idx_i];

  `TSTS_ASSERT_NEXT(a_shift_last, clk_i, rst_ni, wr_en_i && shift_i,
    win_q[WindowDepth-1] == $past(wr_data_i))
  `TSTS_ASSERT_IMP(a_idx_range, clk_i, rst_ni, wr_en_i && !shift_i,
    wr_idx_i < WinIdxW'(WindowDepth))
  `TSTS_ASSERT_IMP(a_rd_range, clk_i, rst_ni, 1'b1,
    rd_idx_i < WinIdxW'(WindowDepth))

endmodule

[sv/tsts_search.sv]
`include "timestamp_sync_trigger_scheduler_assert.svh"

module tsts_search
  import tsts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srch_req_t            req_i,
  input  logic [31:0]          now_i,
  output logic [WinIdxW-1:0]   rd_idx_o,
  input  logic [31:0]          sync_rd_i,
  input  logic [31:0]          arr_rd_i,
  input  logic [31:0]          glob_rd_i,
  output srch_sts_t            sts_o,
  output logic [31:0]          lag_o,
  output logic [31:0]          cycle_o,
  output logic [31:0]          sched_o,
  output logic                 capped_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StStep = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [WinIdxW-1:0] idx_q, idx_d;
  logic [31:0]        prev_a_q, prev_a_d, prev_g_q, prev_g_d;
  logic [31:0]        lag_q, lag_d, cyc_q, cyc_d;
  logic [31:0]        cand_q, cand_d, n_q, n_d;
  logic               capped_q, capped_d, strict_q, strict_d, done_d, done_q;
  logic [31:0]        a_diff, c_diff, next_cand, gap;
  logic               ok;

  assign rd_idx_o  = idx_q;
  assign a_diff    = sync_rd_i - prev_a_q;
  assign c_diff    = glob_rd_i - prev_g_q;
  assign next_cand = cand_q + cyc_q;
  assign gap       = next_cand - now_i;
  assign ok        = !gap[31] && !(strict_q && (gap == '0));

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    prev_a_d = prev_a_q;
    prev_g_d = prev_g_q;
    lag_d    = lag_q;
    cyc_d    = cyc_q;
    cand_d   = cand_q;
    n_d      = n_q;
    capped_d = capped_q;
    strict_d = strict_q;
    done_d   = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_i.start) begin
          state_d  = StScan;
          idx_d    = '0;
          strict_d = req_i.strict_mode;
        end
      end
      StScan: begin
        prev_a_d = arr_rd_i;
        prev_g_d = glob_rd_i;
        if (idx_q == WinIdxW'(1)) begin
          lag_d = a_diff;
          cyc_d = c_diff;
        end else if (idx_q != '0) begin
          if (a_diff < lag_q) lag_d = a_diff;
          if (c_diff < cyc_q) cyc_d = c_diff;
        end
        if (idx_q == WinIdxW'(WindowDepth - 1)) begin
          state_d = StStep;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StStep: begin
        // index still on the last entry: glob_rd_i is the newest global stamp
        if (idx_q == WinIdxW'(WindowDepth - 1)) begin
          cand_d = glob_rd_i - lag_q;
          n_d    = 32'd1;
          idx_d  = '0;
        end else begin
          cand_d = next_cand;
          if (ok) begin
            capped_d = 1'b0;
            state_d  = StIdle;
            done_d   = 1'b1;
          end else if (cyc_q == '0 || n_q == MaxPeriods) begin
            capped_d = 1'b1;
            state_d  = StIdle;
            done_d   = 1'b1;
          end else begin
            n_d = n_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      lag_q    <= '0;
      cyc_q    <= '0;
      cand_q   <= '0;
      capped_q <= 1'b0;
      strict_q <= 1'b0;
      done_q   <= 1'b0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      lag_q    <= lag_d;
      cyc_q    <= cyc_d;
      cand_q   <= cand_d;
      capped_q <= capped_d;
      strict_q <= strict_d;
      done_q   <= done_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_a_q <= prev_a_d;
    prev_g_q <= prev_g_d;
  end

  assign sts_o.busy = (state_q != StIdle);
  assign sts_o.done = done_q;
  assign lag_o      = lag_q;
  assign cycle_o    = cyc_q;
  assign sched_o    = cand_q;
  assign capped_o   = capped_q;

  `TSTS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_d, state_q == StIdle)
  `TSTS_ASSERT_IMP(a_n_cap, clk_i, rst_ni, state_q == StStep, n_q <= MaxPeriods)
  `TSTS_ASSERT_IMP(a_start_idle, clk_i, rst_ni, req_i.start, state_q == StIdle)

endmodule

[sv/timestamp_sync_trigger_scheduler.sv]
// Trigger scheduler locked to frame timestamps.
// Input channel (in_valid_i/in_ready_o): one transaction per time tick or
// received frame. Output channel (out_valid_o/out_ready_i): one result per
// input transaction, held in an output register until taken.
// Config port: cfg_we_i, cfg_idx_i (0 = sync ID, 1 = global ID), cfg_data_i.
// Each transaction passes StUpd, then StSrch (frames) or StChk, before StOut.
// A search scans the windows, then steps the period grid one candidate per
// cycle, up to 65535 steps; a fire adds a strict search.
// At most one fire per transaction.
// The shared search unit sets the rate; one item is in flight at a time.
// in_ready_o is low while an item is in work or its result is unread.
// Reset clears fill counts, schedule, lag, cycle, counters and the IDs to
// their defaults; windows hold no reset value and are read only once full.
// A stalled receiver holds the result; no new item is taken until it is.
module timestamp_sync_trigger_scheduler
  import tsts_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [28:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           func_i,
  input  logic [31:0]    local_time_i,
  input  logic [28:0]    frame_id_i,
  input  logic [31:0]    frame_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           trigger_fire_o,
  output logic [31:0]    next_trigger_time_o,
  output logic [31:0]    lag_value_o,
  output logic [31:0]    cycle_value_o,
  output logic           synced_o,
  output logic [31:0]    trigger_total_o,
  output logic           search_capped_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StUpd   = 3'd1;
  localparam logic [2:0] StSrch  = 3'd2;
  localparam logic [2:0] StChk   = 3'd3;
  localparam logic [2:0] StFire  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [IdW-1:0]     sync_id_q, glob_id_q;
  logic [FillW-1:0]   sfill_q, gfill_q;
  logic               func_q, fire_q;
  logic [31:0]        now_q, word_q, total_q;
  logic [IdW-1:0]     id_q;
  logic               synced, is_sync, is_glob;
  logic               s_we, s_shift, g_we, g_shift;
  logic [WinIdxW-1:0] rd_idx;
  logic [31:0]        sync_rd, arr_rd, glob_rd;
  srch_req_t          req;
  srch_sts_t          sts;
  logic [31:0]        lag, cyc, sched;
  logic               capped, searched_q;

  assign synced  = (sfill_q == FillW'(WindowDepth)) && (gfill_q == FillW'(WindowDepth));
  assign is_sync = (id_q == sync_id_q);
  assign is_glob = (id_q == glob_id_q);

  always_comb begin
    s_we = 1'b0; s_shift = 1'b0; g_we = 1'b0; g_shift = 1'b0;
    if (state_q == StUpd && func_q) begin
      if (synced) begin
        s_we = is_sync; s_shift = 1'b1;
        g_we = !is_sync && is_glob; g_shift = 1'b1;
      end else begin
        s_we = is_sync && (sfill_q != FillW'(WindowDepth));
        g_we = is_glob && (gfill_q != FillW'(WindowDepth));
      end
    end
  end

  tsts_window u_sync (
    .clk_i, .rst_ni, .wr_en_i(s_we), .shift_i(s_shift),
    .wr_idx_i(sfill_q[WinIdxW-1:0]), .wr_data_i(word_q),
    .rd_idx_i(rd_idx), .rd_data_o(sync_rd)
  );
  tsts_window u_arr (
    .clk_i, .rst_ni, .wr_en_i(s_we), .shift_i(s_shift),
    .wr_idx_i(sfill_q[WinIdxW-1:0]), .wr_data_i(now_q),
    .rd_idx_i(rd_idx), .rd_data_o(arr_rd)
  );
  tsts_window u_glob (
    .clk_i, .rst_ni, .wr_en_i(g_we), .shift_i(g_shift),
    .wr_idx_i(gfill_q[WinIdxW-1:0]), .wr_data_i(word_q),
    .rd_idx_i(rd_idx), .rd_data_o(glob_rd)
  );

  tsts_search u_search (
    .clk_i, .rst_ni, .req_i(req), .now_i(now_q), .rd_idx_o(rd_idx),
    .sync_rd_i(sync_rd), .arr_rd_i(arr_rd), .glob_rd_i(glob_rd),
    .sts_o(sts), .lag_o(lag), .cycle_o(cyc),
    .sched_o(sched), .capped_o(capped)
  );

  logic [31:0] since;
  assign since = now_q - sched;

  always_comb begin
    state_d = state_q;
    req     = '0;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StUpd;
      StUpd: begin
        if (func_q) begin
          // synced after this write?
          state_d = StSrch;
        end else begin
          state_d = StChk;
        end
      end
      StSrch: begin
        if (synced) begin
          req.start = 1'b1;
          state_d   = StFire;
        end else begin
          state_d = StOut;
        end
      end
      StFire: if (sts.done) state_d = StChk;
      StChk: begin
        if (synced && searched_q && !fire_q && !since[31]) begin
          req.start       = 1'b1;
          req.strict_mode = 1'b1;
          state_d         = StFire;
        end else begin
          state_d = StOut;
        end
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic fire_now;
  assign fire_now = (state_q == StChk) && synced && searched_q && !fire_q && !since[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      sync_id_q  <= SyncIdReset;
      glob_id_q  <= GlobalIdReset;
      sfill_q    <= '0;
      gfill_q    <= '0;
      total_q    <= '0;
      fire_q     <= 1'b0;
      searched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSyncId) sync_id_q <= cfg_data_i;
        else if (cfg_idx_i == CfgGlobalId) glob_id_q <= cfg_data_i;
      end
      if (s_we && !s_shift) sfill_q <= sfill_q + 1'b1;
      if (g_we && !g_shift) gfill_q <= gfill_q + 1'b1;
      if (state_q == StIdle && in_valid_i) fire_q <= 1'b0;
      if (fire_now) begin
        fire_q  <= 1'b1;
        total_q <= total_q + 1'b1;
      end
      if (req.start) searched_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      func_q <= func_i;
      now_q  <= local_time_i;
      id_q   <= frame_id_i;
      word_q <= frame_word_i;
    end
  end

  // StFire waits for the search to finish, then StChk may fire.
  // A transaction fires at most once; a capped strict point may still be <= now.

  assign in_ready_o          = (state_q == StIdle);
  assign out_valid_o         = (state_q == StOut);
  assign trigger_fire_o      = fire_q;
  assign next_trigger_time_o = synced ? sched : '0;
  assign lag_value_o         = synced ? lag : '0;
  assign cycle_value_o       = synced ? cyc : '0;
  assign synced_o            = synced;
  assign trigger_total_o     = total_q;
  assign search_capped_o     = synced ? capped : 1'b0;

  `TSTS_ASSERT_IMP(a_ready_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `TSTS_ASSERT_NEXT(a_fire_cnt, clk_i, rst_ni, fire_now, total_q == $past(total_q) + 32'd1)
  `TSTS_ASSERT_IMP(a_fill_max, clk_i, rst_ni, 1'b1,
    sfill_q <= FillW'(WindowDepth) && gfill_q <= FillW'(WindowDepth))

endmodule

[verif/timestamp_sync_trigger_scheduler_tb.sv]
`timescale 1ns / 100ps

module timestamp_sync_trigger_scheduler_tb;
  import tsts_pkg::*;

  localparam int ItemCount  = 1600;
  localparam int WatchLimit = 1000000;

  typedef struct packed {
    logic        func;
    logic [31:0] now;
    logic [28:0] id;
    logic [31:0] word;
  } tick_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] next_time;
    logic [31:0] lag;
    logic [31:0] cycle;
    logic        synced;
    logic [31:0] total;
    logic        capped;
  } sched_t;

  typedef struct {
    tick_t  tick;
    logic   has_exp;
    sched_t exp;
  } row_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_idx_i;
  logic [28:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic        func_i;
  logic [31:0] local_time_i, frame_word_i;
  logic [28:0] frame_id_i;
  logic        out_valid_o, out_ready_i;
  logic        trigger_fire_o, synced_o, search_capped_o;
  logic [31:0] next_trigger_time_o, lag_value_o, cycle_value_o, trigger_total_o;

  timestamp_sync_trigger_scheduler uut (.*);

  // predictor state
  logic [28:0] sync_id_m, global_id_m;
  logic [31:0] sync_w [WindowDepth];
  logic [31:0] arr_w [WindowDepth];
  logic [31:0] glob_w [WindowDepth];
  int          sync_n, glob_n;
  logic [31:0] sched_m, lag_m, cycle_m, total_m;
  logic        capped_m;

  sched_t expected_q[$];
  int     errors, mismatches, n_sent, n_recv, n_fired, n_capped;
  int     idle_in_pct, stall_pct, hold_cycles;
  logic   hold_req;
  int     quiet;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic locked();
    return sync_n >= WindowDepth && glob_n >= WindowDepth;
  endfunction

  function automatic void run_search(logic [31:0] now, logic strict);
    logic [31:0] a, c, lg, cy, cand, d;
    lg = '0;
    cy = '0;
    for (int i = 1; i < WindowDepth; i++) begin
      a = sync_w[i] - arr_w[i-1];
      c = glob_w[i] - glob_w[i-1];
      if (i == 1 || a < lg) lg = a;
      if (i == 1 || c < cy) cy = c;
    end
    lag_m = lg;
    cycle_m = cy;
    cand = glob_w[WindowDepth-1] - lg;
    capped_m = 1'b1;
    for (longint n = 1; n <= longint'(MaxPeriods); n++) begin
      cand += cy;
      d = cand - now;
      if (!d[31] && !(strict && d == 0)) begin
        capped_m = 1'b0;
        break;
      end
      if (cy == 0) break;
    end
    sched_m = cand;
  endfunction

  function automatic void shift_word(ref logic [31:0] w [WindowDepth], input logic [31:0] v);
    for (int i = 0; i < WindowDepth - 1; i++) w[i] = w[i+1];
    w[WindowDepth-1] = v;
  endfunction

  function automatic sched_t schedule_tick(tick_t t);
    sched_t r;
    logic [31:0] d;
    r.fire = 1'b0;
    if (t.func) begin
      if (!locked()) begin
        if (t.id == sync_id_m && sync_n < WindowDepth) begin
          sync_w[sync_n] = t.word;
          arr_w[sync_n] = t.now;
          sync_n++;
        end
        if (t.id == global_id_m && glob_n < WindowDepth) begin
          glob_w[glob_n] = t.word;
          glob_n++;
        end
        if (locked()) run_search(t.now, 1'b0);
      end else begin
        if (t.id == sync_id_m) begin
          shift_word(arr_w, t.now);
          shift_word(sync_w, t.word);
        end else if (t.id == global_id_m) begin
          shift_word(glob_w, t.word);
        end
        run_search(t.now, 1'b0);
      end
    end
    d = t.now - sched_m;
    if (locked() && !d[31]) begin
      r.fire = 1'b1;
      total_m++;
      run_search(t.now, 1'b1);
    end
    r.next_time = sched_m;
    r.lag = lag_m;
    r.cycle = cycle_m;
    r.synced = locked();
    r.total = total_m;
    r.capped = capped_m;
    return r;
  endfunction

  function automatic void model_reset();
    sync_id_m = SyncIdReset;
    global_id_m = GlobalIdReset;
    sync_n = 0;
    glob_n = 0;
    sched_m = '0;
    lag_m = '0;
    cycle_m = '0;
    total_m = '0;
    capped_m = 1'b0;
  endfunction

  task automatic send(tick_t t);
    in_valid_i   <= 1'b1;
    func_i       <= t.func;
    local_time_i <= t.now;
    frame_id_i   <= t.id;
    frame_word_i <= t.word;
    expected_q.push_back(schedule_tick(t));
    n_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    while (($urandom % 100) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [28:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSyncId) sync_id_m = v;
    else global_id_m = v;
  endtask

  // receiver side and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sched_t got, ex;
        got = '{trigger_fire_o, next_trigger_time_o, lag_value_o, cycle_value_o,
                synced_o, trigger_total_o, search_capped_o};
        n_recv++;
        if (expected_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected transaction %p", got);
        end else begin
          ex = expected_q.pop_front();
          if (got.fire) n_fired++;
          if (got.capped) n_capped++;
          if (got !== ex) begin
            errors++;
            if (mismatches++ < 10) $display("exp %p\n got %p", ex, got);
          end
        end
      end
      if (hold_req) out_ready_i <= 1'b0;
      else out_ready_i <= (($urandom % 100) >= stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_req <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      hold_req <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WatchLimit) begin
      $display("watchdog expired");
      $display("timestamp_sync_trigger_scheduler: mismatch");
      $finish;
    end
  end

  function automatic tick_t rand_tick(logic [31:0] now, int mode);
    tick_t t;
    t.now  = now;
    t.func = 1'b1;
    t.word = $urandom;
    case (mode)
      0: t.id = sync_id_m;
      1: t.id = global_id_m;
      2: t.id = $urandom;
      default: begin
        t.func = 1'b0;
        t.id = $urandom;
      end
    endcase
    return t;
  endfunction

  // random phase: well-formed stamps with noise, on a time base near the last one
  task automatic random_phase(int count, ref logic [31:0] now);
    tick_t t;
    logic [31:0] gstamp, sstamp;
    int kind;
    gstamp = now + $urandom_range(0, 3000);
    sstamp = now + $urandom_range(0, 500);
    for (int k = 0; k < count; k++) begin
      now += $urandom_range(1, 400);
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        sstamp = now + $urandom_range(0, 300);
        t = rand_tick(now, 0);
        t.word = sstamp;
      end else if (kind < 40) begin
        gstamp += $urandom_range(50, 2000);
        t = rand_tick(now, 1);
        t.word = gstamp;
      end else if (kind < 44) begin
        t = rand_tick(now, $urandom_range(0, 2));
      end else if (kind < 47) begin
        t = rand_tick($urandom, 3);
      end else begin
        t = rand_tick(now, 3);
      end
      send(t);
    end
  endtask

  row_t rows[$];

  initial begin
    logic [31:0] now;
    tick_t t;
    sched_t r;
    errors = 0; mismatches = 0; n_sent = 0; n_recv = 0; n_fired = 0; n_capped = 0;
    idle_in_pct = 0; stall_pct = 0; hold_cycles = 0; hold_req = 1'b0; quiet = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0; func_i = 1'b0; local_time_i = '0; frame_id_i = '0;
    frame_word_i = '0; out_ready_i = 1'b1;
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: idle results, foreign id, then fill windows
    rows.push_back('{'{1'b0, 32'hFFFF_FFFF, 29'h1FFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0});
    rows.push_back('{'{1'b1, 32'h0, 29'h0, 32'h0}, 1'b1, '0});
    rows.push_back('{'{1'b1, 32'hFFFF_FFFF, 29'h1FFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0});
    for (int i = 0; i < 10; i++) begin
      rows.push_back('{'{1'b1, 32'(1000 + 100*i), SyncIdReset, 32'(1010 + 100*i)}, 1'b0, '0});
      if (i < 9)
        rows.push_back('{'{1'b1, 32'(1005 + 100*i), GlobalIdReset, 32'(100*i)}, 1'b0, '0});
    end
    // surplus sync frame dropped, then the filling global frame
    rows.push_back('{'{1'b1, 32'd2990, SyncIdReset, 32'd7}, 1'b0, '0});
    rows.push_back('{'{1'b1, 32'd3000, GlobalIdReset, 32'd900}, 1'b0, '0});
    rows.push_back('{'{1'b0, 32'd3500, 29'd0, 32'd0}, 1'b0, '0});
    foreach (rows[k]) begin
      r = schedule_tick(rows[k].tick);
      if (rows[k].has_exp && r !== rows[k].exp) begin
        errors++;
        $display("table row %0d disagrees with predictor", k);
      end
      expected_q.push_back(rows[k].has_exp ? rows[k].exp : r);
      t = rows[k].tick;
      in_valid_i <= 1'b1;
      func_i <= t.func; local_time_i <= t.now; frame_id_i <= t.id; frame_word_i <= t.word;
      n_sent++;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    drain();
    now = 32'd3500;

    // phases with idling, plus a long receiver hold while the sender keeps offering
    random_phase(300, now);
    hold_cycles <= 2000;
    random_phase(100, now);
    drain();
    idle_in_pct = 82; random_phase(250, now); drain();
    idle_in_pct = 0; stall_pct = 82; random_phase(250, now); drain();

    // equal IDs with constant sync words, new IDs over a time wrap, then reset IDs
    write_reg(CfgSyncId, 29'h1FFF_FFFF);
    write_reg(CfgGlobalId, 29'h1FFF_FFFF);
    idle_in_pct = 35; stall_pct = 35;
    for (int i = 0; i < 12; i++) begin
      now += 50;
      t = rand_tick(now, 0);
      t.word = 32'd5;
      send(t);
    end
    random_phase(200, now);
    drain();
    write_reg(CfgSyncId, 29'd0);
    write_reg(CfgGlobalId, 29'd1);
    idle_in_pct = 0; stall_pct = 0;
    now = 32'hFFFF_F000;
    for (int i = 0; i < 10; i++) begin
      now += 100;
      t = rand_tick(now, 1);
      t.word = 32'hFFFF_F000 + 32'(i*150);
      send(t);
    end
    random_phase(250, now);
    drain();
    write_reg(CfgSyncId, SyncIdReset);
    write_reg(CfgGlobalId, GlobalIdReset);
    random_phase(200, now);
    drain();

    $display("%0d transactions in, %0d out; %0d fires, %0d capped searches",
             n_sent, n_recv, n_fired, n_capped);
    $display("covered window fill, equal IDs, time wrap, long output hold, idle mixes");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("timestamp_sync_trigger_scheduler: match");
    end else begin
      $display("timestamp_sync_trigger_scheduler: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/tsts_pkg.sv
sv/tsts_window.sv
sv/tsts_search.sv
sv/timestamp_sync_trigger_scheduler.sv
verif/timestamp_sync_trigger_scheduler_tb.sv
